FILE: rtl/apc_pkg.sv
`default_nettype none
package apc_pkg;

    localparam int unsigned BP_W     = 12;
    localparam int unsigned CORR_W   = 12;
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned CFG_W    = 6;
    localparam int unsigned OUT_W    = 14;
    localparam int unsigned DIFF_W   = CORR_W + 1;
    localparam int unsigned PROD_W   = 2 * BP_W;
    localparam int unsigned NUM_W    = PROD_W + 2;
    localparam int unsigned NUMS_W   = NUM_W + 1;
    localparam int unsigned DEN_W    = BP_W + 1;
    localparam int unsigned QUOT_W   = DEN_W;
    localparam int unsigned MUL_CNT_W = $clog2(BP_W);
    localparam int unsigned DIV_CNT_W = $clog2(NUM_W);

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 6'd22;

    typedef struct packed {
        logic        [BP_W-1:0]   bp;
        logic signed [CORR_W-1:0] corr;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL_START,
        ST_MUL,
        ST_NUM,
        ST_DIV_START,
        ST_DIV,
        ST_POST,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/apc_if.sv
`default_nettype none
interface apc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  mode;
    logic        [apc_pkg::IDX_W-1:0]      entry_index;
    logic        [apc_pkg::BP_W-1:0]       entry_point;
    logic signed [apc_pkg::CORR_W-1:0]     entry_correction;
    logic        [apc_pkg::SAMPLE_W-1:0]   sample;

    modport source (output valid, mode, entry_index, entry_point, entry_correction, sample,
                    input ready);
    modport sink (input valid, mode, entry_index, entry_point, entry_correction, sample,
                  output ready);
endinterface

interface apc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [apc_pkg::OUT_W-1:0]  corrected;
    logic                              out_of_range;

    modport source (output valid, corrected, out_of_range, input ready);
    modport sink (input valid, corrected, out_of_range, output ready);
endinterface
`default_nettype wire

FILE: rtl/apc_table.sv
`default_nettype none
module apc_table #(
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire apc_pkg::t_entry          i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output apc_pkg::t_entry               o_rdata
);

    apc_pkg::t_entry r_mem [DEPTH];
    apc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/apc_mul.sv
`default_nettype none
module apc_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [apc_pkg::BP_W-1:0]     i_mcand,
    input  wire logic [apc_pkg::BP_W-1:0]     i_mplier,
    output logic                              o_done,
    output logic [apc_pkg::PROD_W-1:0]        o_product
);

    localparam logic [apc_pkg::MUL_CNT_W-1:0] LastStep =
        apc_pkg::MUL_CNT_W'(apc_pkg::BP_W - 1);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [apc_pkg::MUL_CNT_W-1:0]     r_cnt, n_cnt;
    logic [apc_pkg::BP_W-1:0]          r_mcand, n_mcand;
    logic [apc_pkg::BP_W-1:0]          r_acc, n_acc;
    logic [apc_pkg::BP_W-1:0]          r_mpl, n_mpl;
    logic [apc_pkg::BP_W:0]            sum;

    // shift-and-add, one multiplier bit per cycle
    always_comb begin
        sum     = {1'b0, r_acc} + (r_mpl[0] ? {1'b0, r_mcand} : '0);
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_mcand = r_mcand;
        n_acc   = r_acc;
        n_mpl   = r_mpl;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_mcand = i_mcand;
            n_acc   = '0;
            n_mpl   = i_mplier;
        end else if (r_busy) begin
            n_acc = sum[apc_pkg::BP_W:1];
            n_mpl = {sum[0], r_mpl[apc_pkg::BP_W-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LastStep) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mcand <= n_mcand;
        r_acc   <= n_acc;
        r_mpl   <= n_mpl;
    end

    assign o_done    = r_done;
    assign o_product = {r_acc, r_mpl};

endmodule
`default_nettype wire

FILE: rtl/apc_div.sv
`default_nettype none
module apc_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [apc_pkg::NUM_W-1:0]    i_num,
    input  wire logic [apc_pkg::DEN_W-1:0]    i_den,
    output logic                              o_done,
    output logic [apc_pkg::QUOT_W-1:0]        o_quot,
    output logic                              o_rem_nz
);

    localparam logic [apc_pkg::DIV_CNT_W-1:0] LastStep =
        apc_pkg::DIV_CNT_W'(apc_pkg::NUM_W - 1);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [apc_pkg::DIV_CNT_W-1:0]     r_cnt, n_cnt;
    logic [apc_pkg::NUM_W-1:0]         r_num, n_num;
    logic [apc_pkg::DEN_W:0]           r_rem, n_rem;
    logic [apc_pkg::DEN_W-1:0]         r_den, n_den;
    logic [apc_pkg::DEN_W:0]           rem_sh;
    logic                              ge;

    // restoring division: numerator shifts out the top, quotient bits shift in below
    always_comb begin
        rem_sh = {r_rem[apc_pkg::DEN_W-1:0], r_num[apc_pkg::NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            n_num = {r_num[apc_pkg::NUM_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LastStep) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done   = r_done;
    assign o_quot   = r_num[apc_pkg::QUOT_W-1:0];
    assign o_rem_nz = |r_rem;

endmodule
`default_nettype wire

FILE: rtl/adc_piecewise_linear_correction.sv
// ADC piecewise-linear correction.
// Input channel i_in_ch (valid/ready) carries one word per item: mode 0 loads
// breakpoint and correction at entry_index, mode 1 corrects sample. Every word
// gives exactly one result word on o_out_ch: corrected and out_of_range (zero
// for a load). The entry count register is written through i_cfg_we /
// i_cfg_wdata; the user must write it only while the block is idle, as the
// block does not enforce this. Below 2 it acts as 2, above depth as depth.
// Flow: a load goes straight to its result. A correct word scans the table
// through the memory read port, one entry per cycle, up to the first
// breakpoint at or above the sample; an exact match, a hit on the first entry
// or the end of the table finishes there. Interpolation adds a bit-serial
// multiplier, a bit-serial divider and set-up and wrap-up states.
// One word is worked on at a time; the next is taken once the result sits in
// the output register, which holds it while the receiver stalls.
// Synchronous reset clears the control state and sets the entry count to 22;
// the table itself is undefined until loaded.
`default_nettype none
module adc_piecewise_linear_correction #(
    parameter int unsigned TABLE_DEPTH = 32,
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    apc_in_if.sink                            i_in_ch,
    apc_out_if.source                         o_out_ch,
    input  wire logic                         i_cfg_we,
    input  wire logic [apc_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [apc_pkg::SAMPLE_W-1:0] SampleMask =
        apc_pkg::SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    apc_pkg::t_state                     r_state, n_state;
    logic [apc_pkg::CFG_W-1:0]           r_entries;
    logic [apc_pkg::SAMPLE_W-1:0]        r_sample, n_sample;
    logic [CW-1:0]                       r_addr, n_addr;
    logic [CW-1:0]                       r_n, n_n;
    logic [AW-1:0]                       r_ridx, n_ridx;
    logic                                r_rvalid, n_rvalid;
    apc_pkg::t_entry                     r_prev, n_prev;
    apc_pkg::t_entry                     r_hi, n_hi;
    logic [apc_pkg::OUT_W-1:0]           r_corr, n_corr;
    logic                                r_flag, n_flag;
    logic                                r_dcneg, n_dcneg;
    logic                                r_qneg, n_qneg;
    logic signed [apc_pkg::NUMS_W-1:0]   r_num, n_num;
    logic                                r_out_valid, n_out_valid;
    logic [apc_pkg::OUT_W-1:0]           r_out_corr, n_out_corr;
    logic                                r_out_flag, n_out_flag;

    logic                                accept;
    logic                                load_we;
    apc_pkg::t_entry                     load_data;
    apc_pkg::t_entry                     rdata;
    logic [CW-1:0]                       clamp_n;
    logic                                scan_hit, scan_eq, scan_first, scan_last;
    logic                                out_free;
    logic [apc_pkg::DIFF_W-1:0]          dc;
    logic [apc_pkg::BP_W-1:0]            dc_mag;
    logic [apc_pkg::BP_W-1:0]            ds;
    logic [apc_pkg::BP_W-1:0]            dx;
    logic [apc_pkg::NUMS_W-1:0]          num_mag;
    logic [apc_pkg::OUT_W-1:0]           qx, qs;
    logic [apc_pkg::OUT_W-1:0]           rd_corr_x, prev_corr_x;
    logic                                mul_start, mul_done;
    logic [apc_pkg::PROD_W-1:0]          product;
    logic                                div_start, div_done, rem_nz;
    logic [apc_pkg::QUOT_W-1:0]          quot;

    // ---------------- table ----------------
    assign accept    = i_in_ch.valid && i_in_ch.ready;
    assign load_we   = accept && !i_in_ch.mode && (32'(i_in_ch.entry_index) < TABLE_DEPTH);
    assign load_data = '{bp: i_in_ch.entry_point, corr: i_in_ch.entry_correction};

    apc_table #(.DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (AW'(i_in_ch.entry_index)),
        .i_wdata (load_data),
        .i_raddr (AW'(r_addr)),
        .o_rdata (rdata)
    );

    apc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (dc_mag),
        .i_mplier  (ds),
        .o_done    (mul_done),
        .o_product (product)
    );

    apc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (num_mag[apc_pkg::NUM_W-1:0]),
        .i_den    ({dx, 1'b0}),
        .o_done   (div_done),
        .o_quot   (quot),
        .o_rem_nz (rem_nz)
    );

    // ---------------- shared arithmetic ----------------
    always_comb begin
        if (r_entries < apc_pkg::CFG_W'(2)) begin
            clamp_n = CW'(2);
        end else if (32'(r_entries) > TABLE_DEPTH) begin
            clamp_n = CW'(TABLE_DEPTH);
        end else begin
            clamp_n = CW'(r_entries);
        end
    end

    assign scan_hit   = r_rvalid && (rdata.bp >= r_sample);
    assign scan_eq    = rdata.bp == r_sample;
    assign scan_first = r_ridx == '0;
    assign scan_last  = CW'(r_ridx) == (r_n - CW'(1));
    assign out_free   = !r_out_valid || o_out_ch.ready;

    assign rd_corr_x   = {{(apc_pkg::OUT_W - apc_pkg::CORR_W){rdata.corr[apc_pkg::CORR_W-1]}},
                          rdata.corr};
    assign prev_corr_x = {{(apc_pkg::OUT_W - apc_pkg::CORR_W){r_prev.corr[apc_pkg::CORR_W-1]}},
                          r_prev.corr};

    assign dc     = {r_hi.corr[apc_pkg::CORR_W-1], r_hi.corr}
                  - {r_prev.corr[apc_pkg::CORR_W-1], r_prev.corr};
    assign dc_mag = dc[apc_pkg::DIFF_W-1] ? apc_pkg::BP_W'(~dc + 1'b1)
                                          : dc[apc_pkg::BP_W-1:0];
    assign ds     = r_sample - r_prev.bp;
    assign dx     = r_hi.bp - r_prev.bp;
    assign num_mag = r_num[apc_pkg::NUMS_W-1] ? (~r_num + 1'b1) : r_num;
    // floor of a negative quotient steps down by one when the division is inexact
    assign qx      = {1'b0, quot} + {{(apc_pkg::OUT_W - 1){1'b0}}, rem_nz & r_qneg};
    assign qs      = r_qneg ? (~qx + 1'b1) : qx;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            apc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = i_in_ch.mode ? apc_pkg::ST_SCAN : apc_pkg::ST_DONE;
                end
            end
            apc_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    n_state = (scan_eq || scan_first) ? apc_pkg::ST_DONE
                                                      : apc_pkg::ST_MUL_START;
                end else if (r_rvalid && scan_last) begin
                    n_state = apc_pkg::ST_DONE;
                end
            end
            apc_pkg::ST_MUL_START: n_state = apc_pkg::ST_MUL;
            apc_pkg::ST_MUL: begin
                if (mul_done) begin
                    n_state = apc_pkg::ST_NUM;
                end
            end
            apc_pkg::ST_NUM:       n_state = apc_pkg::ST_DIV_START;
            apc_pkg::ST_DIV_START: n_state = apc_pkg::ST_DIV;
            apc_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = apc_pkg::ST_POST;
                end
            end
            apc_pkg::ST_POST:      n_state = apc_pkg::ST_DONE;
            apc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = apc_pkg::ST_IDLE;
                end
            end
            default:               n_state = apc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    always_comb begin
        i_in_ch.ready = 1'b0;
        mul_start     = 1'b0;
        div_start     = 1'b0;
        case (r_state)
            apc_pkg::ST_IDLE:      i_in_ch.ready = 1'b1;
            apc_pkg::ST_MUL_START: mul_start     = 1'b1;
            apc_pkg::ST_DIV_START: div_start     = 1'b1;
            default: begin
                i_in_ch.ready = 1'b0;
            end
        endcase
    end

    // ---------------- datapath ----------------
    always_comb begin
        n_sample    = r_sample;
        n_addr      = r_addr;
        n_n         = r_n;
        n_ridx      = r_ridx;
        n_rvalid    = r_rvalid;
        n_prev      = r_prev;
        n_hi        = r_hi;
        n_corr      = r_corr;
        n_flag      = r_flag;
        n_dcneg     = r_dcneg;
        n_qneg      = r_qneg;
        n_num       = r_num;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        n_out_corr  = r_out_corr;
        n_out_flag  = r_out_flag;
        case (r_state)
            apc_pkg::ST_IDLE: begin
                n_addr   = '0;
                n_rvalid = 1'b0;
                n_n      = clamp_n;
                n_sample = i_in_ch.sample & SampleMask;
                n_corr   = '0;
                n_flag   = 1'b0;
                if (!i_in_ch.mode) begin
                    n_sample = '0;
                end
            end
            apc_pkg::ST_SCAN: begin
                // read port runs one entry ahead of the compare
                if (r_addr != r_n) begin
                    n_addr = r_addr + CW'(1);
                end
                n_rvalid = r_addr != r_n;
                n_ridx   = AW'(r_addr);
                if (scan_hit) begin
                    n_corr = rd_corr_x;
                    n_flag = !scan_eq && scan_first;
                    n_hi   = rdata;
                end else if (r_rvalid) begin
                    n_prev = rdata;
                    if (scan_last) begin
                        n_corr = rd_corr_x;
                        n_flag = 1'b1;
                    end
                end
            end
            apc_pkg::ST_MUL_START: begin
                n_dcneg = dc[apc_pkg::DIFF_W-1];
            end
            apc_pkg::ST_NUM: begin
                if (r_dcneg) begin
                    n_num = apc_pkg::NUMS_W'(dx) - {2'b00, product, 1'b0};
                end else begin
                    n_num = apc_pkg::NUMS_W'(dx) + {2'b00, product, 1'b0};
                end
            end
            apc_pkg::ST_DIV_START: begin
                n_qneg = r_num[apc_pkg::NUMS_W-1];
            end
            apc_pkg::ST_POST: begin
                n_corr = prev_corr_x + qs;
            end
            apc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_corr  = {{(apc_pkg::OUT_W - apc_pkg::SAMPLE_W){1'b0}}, r_sample}
                                + r_corr;
                    n_out_flag  = r_flag;
                end
            end
            default: begin
                n_addr = r_addr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apc_pkg::ST_IDLE;
            r_entries   <= apc_pkg::ENTRIES_RESET;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rvalid    <= n_rvalid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_entries <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_addr     <= n_addr;
        r_n        <= n_n;
        r_ridx     <= n_ridx;
        r_prev     <= n_prev;
        r_hi       <= n_hi;
        r_corr     <= n_corr;
        r_flag     <= n_flag;
        r_dcneg    <= n_dcneg;
        r_qneg     <= n_qneg;
        r_num      <= n_num;
        r_out_corr <= n_out_corr;
        r_out_flag <= n_out_flag;
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.corrected    = r_out_corr;
    assign o_out_ch.out_of_range = r_out_flag;

endmodule
`default_nettype wire
